// File: sv/cpar_pkg.sv
`timescale 1ns / 1ps

package cpar_pkg;

    localparam int DATA_W     = 8;
    localparam int PERIOD_W   = 16;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [PERIOD_W-1:0] RESEND_PERIOD_RST = 16'd1000;

    // register index, taken from paddr[2]
    localparam logic REG_RESEND_PERIOD = 1'b0;

    localparam logic [DATA_W-1:0] CH_START     = 8'h21;
    localparam logic [DATA_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [DATA_W-1:0] CH_RETURN    = 8'h0D;

    localparam int ACK_LEN  = 4;
    localparam int REQ_LEN  = 5;
    // only the leading characters take part in any compare
    localparam int HEAD_LEN = 5;

    localparam logic [0:ACK_LEN-1][DATA_W-1:0] WORD_ACK = {8'h21, 8'h4F, 8'h4B, 8'h23};
    localparam logic [0:REQ_LEN-1][DATA_W-1:0] WORD_REQ = {8'h21, 8'h52, 8'h53, 8'h54, 8'h23};

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_SEND   = 2'd1,
        ACT_RESEND = 2'd2,
        ACT_ACKED  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_REQ  = 2'd1,
        CMD_ACK  = 2'd2
    } t_cmd;

    typedef struct packed {
        logic              en;
        logic              op;
        logic [DATA_W-1:0] rx_byte;
    } t_step;

    typedef struct packed {
        t_action action;
        logic    awaiting_ack;
    } t_result;

endpackage

// File: sv/cpar_if.sv
`timescale 1ns / 1ps

interface cpar_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink (input valid, input op, input rx_byte, output ready);
endinterface

interface cpar_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic       awaiting_ack;

    modport source (output valid, output action, output awaiting_ack, input ready);
    modport sink (input valid, input action, input awaiting_ack, output ready);
endinterface

// File: sv/cpar_cfg.sv
`timescale 1ns / 1ps

module cpar_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cpar_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [cpar_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [cpar_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output logic [cpar_pkg::PERIOD_W-1:0]       o_period
);

    logic [cpar_pkg::PERIOD_W-1:0] r_period;
    logic                          reg_hit;
    logic                          wr_en;

    assign reg_hit = (paddr[2] == cpar_pkg::REG_RESEND_PERIOD);
    assign wr_en   = psel && penable && pwrite && reg_hit;
    assign pready  = 1'b1;
    assign o_period = r_period;

    always_comb begin
        prdata = '0;
        if (reg_hit) begin
            prdata = {{(cpar_pkg::APB_DATA_W - cpar_pkg::PERIOD_W){1'b0}}, r_period};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= cpar_pkg::RESEND_PERIOD_RST;
        end else if (wr_en) begin
            r_period <= pwdata[cpar_pkg::PERIOD_W-1:0];
        end
    end

endmodule

// File: sv/cpar_line.sv
`timescale 1ns / 1ps

module cpar_line #(
    parameter int LINE_CAPACITY = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cpar_pkg::t_step i_step,
    output cpar_pkg::t_cmd  o_cmd
);

    localparam int FW = $clog2(LINE_CAPACITY + 1);

    logic                        r_active;
    logic [FW-1:0]               r_fill;
    logic [cpar_pkg::DATA_W-1:0] r_head [cpar_pkg::HEAD_LEN];

    logic                        n_active;
    logic [FW-1:0]               n_fill;
    logic                        wr;
    logic [FW-1:0]               wr_pos;
    logic                        ack_match;
    logic                        req_match;
    logic [cpar_pkg::DATA_W-1:0] b;

    assign b = i_step.rx_byte;

    always_comb begin
        ack_match = 1'b1;
        for (int i = 0; i < cpar_pkg::ACK_LEN; i++) begin
            ack_match = ack_match && (r_head[i] == cpar_pkg::WORD_ACK[i]);
        end
        req_match = 1'b1;
        for (int i = 0; i < cpar_pkg::REQ_LEN; i++) begin
            req_match = req_match && (r_head[i] == cpar_pkg::WORD_REQ[i]);
        end
    end

    always_comb begin
        n_active = r_active;
        n_fill   = r_fill;
        wr       = 1'b0;
        wr_pos   = r_fill;
        o_cmd    = cpar_pkg::CMD_NONE;
        if (i_step.en && !i_step.op) begin
            if (!r_active) begin
                n_fill = '0;
                if (b == cpar_pkg::CH_START) begin
                    wr       = 1'b1;
                    wr_pos   = '0;
                    n_fill   = FW'(1);
                    n_active = 1'b1;
                end
            end else if (b == cpar_pkg::CH_START) begin
                wr     = 1'b1;
                wr_pos = '0;
                n_fill = FW'(1);
            end else if (b == cpar_pkg::CH_BACKSPACE) begin
                if (r_fill != '0) begin
                    n_fill = r_fill - FW'(1);
                end
                if (n_fill == '0) begin
                    n_active = 1'b0;
                end
            end else if (b == cpar_pkg::CH_RETURN) begin
                if (r_fill == FW'(cpar_pkg::ACK_LEN) && ack_match) begin
                    o_cmd = cpar_pkg::CMD_ACK;
                end else if (r_fill == FW'(cpar_pkg::REQ_LEN) && req_match) begin
                    o_cmd = cpar_pkg::CMD_REQ;
                end
                n_active = 1'b0;
            end else begin
                if (r_fill < FW'(LINE_CAPACITY)) begin
                    wr     = 1'b1;
                    n_fill = r_fill + FW'(1);
                end
                if (n_fill >= FW'(LINE_CAPACITY)) begin
                    n_active = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_fill   <= '0;
        end else begin
            r_active <= n_active;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < cpar_pkg::HEAD_LEN; i++) begin
            if (wr && wr_pos == FW'(i)) begin
                r_head[i] <= b;
            end
        end
    end

endmodule

// File: sv/cpar_ack.sv
`timescale 1ns / 1ps

module cpar_ack (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cpar_pkg::t_step               i_step,
    input  cpar_pkg::t_cmd                i_cmd,
    input  logic [cpar_pkg::PERIOD_W-1:0] i_period,
    output cpar_pkg::t_result             o_res
);

    logic                          r_wait;
    logic [cpar_pkg::PERIOD_W-1:0] r_tick;
    logic                          n_wait;
    logic [cpar_pkg::PERIOD_W-1:0] n_tick;
    logic [cpar_pkg::PERIOD_W:0]   tick_inc;
    logic [cpar_pkg::PERIOD_W-1:0] period_eff;
    cpar_pkg::t_action             action;

    assign tick_inc   = {1'b0, r_tick} + {{cpar_pkg::PERIOD_W{1'b0}}, 1'b1};
    assign period_eff = (i_period == '0) ? {{(cpar_pkg::PERIOD_W-1){1'b0}}, 1'b1} : i_period;

    always_comb begin
        n_wait = r_wait;
        n_tick = r_tick;
        action = cpar_pkg::ACT_NONE;
        if (i_step.en) begin
            if (!i_step.op) begin
                if (i_cmd == cpar_pkg::CMD_REQ) begin
                    n_wait = 1'b1;
                    n_tick = '0;
                    action = cpar_pkg::ACT_SEND;
                end else if (i_cmd == cpar_pkg::CMD_ACK && r_wait) begin
                    n_wait = 1'b0;
                    n_tick = '0;
                    action = cpar_pkg::ACT_ACKED;
                end
            end else if (r_wait) begin
                if (tick_inc >= {1'b0, period_eff}) begin
                    n_tick = '0;
                    action = cpar_pkg::ACT_RESEND;
                end else begin
                    n_tick = tick_inc[cpar_pkg::PERIOD_W-1:0];
                end
            end
        end
    end

    assign o_res.action       = action;
    assign o_res.awaiting_ack = n_wait;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait <= 1'b0;
            r_tick <= '0;
        end else begin
            r_wait <= n_wait;
            r_tick <= n_tick;
        end
    end

endmodule

// File: sv/command_parser_with_ack_resend.sv
`timescale 1ns / 1ps

// Command line parser with acknowledged, periodically resent response.
// i_in carries one item per handshake: op 0 is a received byte in rx_byte,
// op 1 is one timer tick. o_out returns exactly one item per input item:
// the action code (none, send, resend, acked) and the ack-wait flag after
// that step. The APB port holds resend_period at address 0.
// An accepted item is held in the input register, passes the single parse/timer
// step and lands in the output register. Throughput is one item per cycle while
// o_out is not stalled, set by the single step between the two registers.
// When o_out is stalled, the output register holds its item and the input
// register takes one more; i_in.ready drops only while both are full.
// Reset (synchronous, active low) empties both registers, drops any partial
// line, clears the ack wait and tick count, and sets resend_period to 1000.
// There is no clearing pass; the block accepts items right after reset.

module command_parser_with_ack_resend #(
    parameter int LINE_CAPACITY = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    cpar_in_if.sink                         i_in,
    cpar_out_if.source                      o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cpar_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [cpar_pkg::APB_DATA_W-1:0] pwdata,
    output logic [cpar_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    logic                          r_s1_valid;
    logic                          r_s1_op;
    logic [cpar_pkg::DATA_W-1:0]   r_s1_byte;
    logic                          r_out_valid;
    cpar_pkg::t_result             r_out;

    logic                          advance;
    logic                          in_take;
    cpar_pkg::t_step               step;
    cpar_pkg::t_cmd                cmd;
    cpar_pkg::t_result             res;
    logic [cpar_pkg::PERIOD_W-1:0] period;

    assign advance  = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || advance;
    assign in_take  = i_in.valid && i_in.ready;

    assign step.en      = advance;
    assign step.op      = r_s1_op;
    assign step.rx_byte = r_s1_byte;

    cpar_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_period (period)
    );

    cpar_line #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .o_cmd   (cmd)
    );

    cpar_ack u_ack (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_cmd    (cmd),
        .i_period (period),
        .o_res    (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_op   <= i_in.op;
            r_s1_byte <= i_in.rx_byte;
        end
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.action       = r_out.action;
    assign o_out.awaiting_ack = r_out.awaiting_ack;

`ifndef ASSERT_OFF
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid && !r_s1_valid)
        else $error("output valid after reset");

    a_send_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.action == cpar_pkg::ACT_SEND ||
                        o_out.action == cpar_pkg::ACT_RESEND) |-> o_out.awaiting_ack)
        else $error("send or resend without ack wait");

    a_acked_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.action == cpar_pkg::ACT_ACKED |-> !o_out.awaiting_ack)
        else $error("ack wait still set after ack");

    a_resend_only_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && res.action == cpar_pkg::ACT_RESEND |-> r_s1_op)
        else $error("resend from a byte item");

    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid && $stable(r_out))
        else $error("stalled result lost");
`endif

endmodule
